### design/link_impairment_scheduler_assert.svh
// Assertion macros for the link impairment scheduler.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef LINK_IMPAIRMENT_SCHEDULER_ASSERT_SVH
`define LINK_IMPAIRMENT_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lis_pkg.sv
// Shared widths, register codes and item structs of the link impairment scheduler.
// No dependencies; lis_sched and the top level use it.
`timescale 1ns / 1ps

package lis_pkg;

  // Field widths.
  localparam int NOW_W      = 40;
  localparam int ID_W       = 13;
  localparam int PCT_W      = 7;
  localparam int US_W       = 24;
  localparam int DLY_W      = 32;
  localparam int CNT_W      = 32;
  localparam int NOM_W      = US_W + 1;
  localparam int SUM_W      = NOW_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Number of packet id slots; a power of two, so the reduction is a mask.
  localparam int ID_SLOTS = 8192;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'(ID_SLOTS - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_PCT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_PCT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_LAT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LAT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDERED    = 3'd5;

  // One packet send.
  typedef struct packed {
    logic [NOW_W-1:0] now_us;
    logic [ID_W-1:0]  pkt_id;
    logic             upstream;
    logic [PCT_W-1:0] loss_draw;
    logic [PCT_W-1:0] dup_draw;
    logic [US_W-1:0]  jitter_draw;
    logic [US_W-1:0]  twin_jitter_draw;
  } in_item_t;

  // One scheduling result.
  typedef struct packed {
    logic [ID_W-1:0]  out_pkt_id;
    logic             is_twin;
    logic [DLY_W-1:0] delay_us;
    logic             toward_server;
    logic             was_dropped;
    logic             link_reset;
    logic             last;
    logic [CNT_W-1:0] sent_total;
    logic [CNT_W-1:0] dropped_total;
    logic [CNT_W-1:0] duplicated_total;
  } out_item_t;

  // Packet held in the scheduling stage, with both nominal arrivals precomputed.
  typedef struct packed {
    logic [NOW_W-1:0] now_us;
    logic [ID_W-1:0]  pkt_id;
    logic             upstream;
    logic             loss;
    logic             dup;
    logic [NOM_W-1:0] nom1;
    logic [NOM_W-1:0] nom2;
    logic [SUM_W-1:0] at1;
    logic [SUM_W-1:0] at2;
  } b_item_t;

  // One copy handed to the scheduler core.
  typedef struct packed {
    logic [NOW_W-1:0] now_us;
    logic [SUM_W-1:0] at;
    logic [NOM_W-1:0] nom;
    logic             upstream;
    logic             loss;
    logic             dup;
    logic             twin;
  } sched_req_t;

  // Delay and counter values returned for that copy.
  typedef struct packed {
    logic [DLY_W-1:0] delay_us;
    logic [CNT_W-1:0] sent_total;
    logic [CNT_W-1:0] dropped_total;
    logic [CNT_W-1:0] duplicated_total;
  } sched_res_t;

endpackage

### design/lis_stream_if.sv
// Valid/ready stream interface carrying one item per handshake.
// The payload type comes from lis_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface lis_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/lis_sched.sv
// Scheduler core: per-direction arrival cursors and the send/drop/duplicate counters.
// Schedules one packet copy per cycle while issue is high. Depends on lis_pkg.
`timescale 1ns / 1ps

module lis_sched (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ordered,
  input  logic               issue,
  input  lis_pkg::sched_req_t req,
  output lis_pkg::sched_res_t res
);

  logic [lis_pkg::NOW_W-1:0] up_cursor_r, up_cursor_nxt;
  logic [lis_pkg::NOW_W-1:0] down_cursor_r, down_cursor_nxt;
  logic [lis_pkg::CNT_W-1:0] sent_r, sent_nxt;
  logic [lis_pkg::CNT_W-1:0] dropped_r, dropped_nxt;
  logic [lis_pkg::CNT_W-1:0] duplicated_r, duplicated_nxt;

  logic [lis_pkg::NOW_W-1:0] cur;
  logic [lis_pkg::SUM_W-1:0] cur_p1;
  logic [lis_pkg::SUM_W-1:0] dly_push;
  logic [lis_pkg::SUM_W-1:0] dly_full;
  logic [lis_pkg::SUM_W-1:0] new_at;
  logic [lis_pkg::NOW_W-1:0] new_cur;
  logic                      push;
  logic                      first;
  logic                      move_cur;

  // An ordered link never lets a copy arrive at or before the last arrival.
  assign cur      = req.upstream ? up_cursor_r : down_cursor_r;
  assign cur_p1   = {1'b0, cur} + lis_pkg::SUM_W'(1);
  assign push     = ordered && (req.at <= {1'b0, cur});
  assign dly_push = cur_p1 - {1'b0, req.now_us};
  assign dly_full = push ? dly_push : lis_pkg::SUM_W'(req.nom);

  // The cursor saturates rather than wrapping.
  assign new_at  = push ? cur_p1 : req.at;
  assign new_cur = new_at[lis_pkg::NOW_W] ? {lis_pkg::NOW_W{1'b1}}
                                          : new_at[lis_pkg::NOW_W-1:0];

  // Delay saturates at the field width; a lost packet reports zero.
  assign res.delay_us = req.loss ? '0 :
                        (|dly_full[lis_pkg::SUM_W-1:lis_pkg::DLY_W]) ? {lis_pkg::DLY_W{1'b1}}
                                                                    : dly_full[lis_pkg::DLY_W-1:0];

  // Cursor update, only for kept copies on an ordered link.
  assign move_cur = issue && ordered && !req.loss;

  always_comb begin
    up_cursor_nxt   = up_cursor_r;
    down_cursor_nxt = down_cursor_r;
    if (move_cur) begin
      if (req.upstream) begin
        up_cursor_nxt = new_cur;
      end else begin
        down_cursor_nxt = new_cur;
      end
    end
  end

  // Counters advance once per packet, on its first copy; both copies report the new values.
  assign first          = !req.twin;
  assign sent_nxt       = sent_r + lis_pkg::CNT_W'(first);
  assign dropped_nxt    = dropped_r + lis_pkg::CNT_W'(first && req.loss);
  assign duplicated_nxt = duplicated_r + lis_pkg::CNT_W'(first && !req.loss && req.dup);

  assign res.sent_total       = sent_nxt;
  assign res.dropped_total    = dropped_nxt;
  assign res.duplicated_total = duplicated_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_cursor_r   <= '0;
      down_cursor_r <= '0;
      sent_r        <= '0;
      dropped_r     <= '0;
      duplicated_r  <= '0;
    end else begin
      up_cursor_r   <= up_cursor_nxt;
      down_cursor_r <= down_cursor_nxt;
      if (issue) begin
        sent_r       <= sent_nxt;
        dropped_r    <= dropped_nxt;
        duplicated_r <= duplicated_nxt;
      end
    end
  end

endmodule

### design/link_impairment_scheduler.sv
// Top level of the link impairment scheduler: config registers, input stage,
// scheduling stage and result register. Depends on lis_pkg, lis_stream_if,
// lis_sched and link_impairment_scheduler_assert.svh.
//
// Usage:
//   in_ch carries one packet send per item (time, id, direction, random draws).
//   out_ch carries one result per scheduled copy: one for a dropped or single packet,
//   two (original, then twin with last set) for a duplicated packet.
//   cfg_we/cfg_idx/cfg_data write the six link registers; write only while idle.
//   Each result passes the input register, then the scheduling register,
//   then the result register. A duplicated item holds the scheduling stage
//   for both of its copies while the input stage can take the next item; on
//   an ordered link the direction cursor moves once per kept copy.
//   A stalled receiver holds the result register; the two stages ahead of it
//   keep taking items until they are full, then in_ch.ready drops.
//   Reset (synchronous, rst_n low) clears the config registers, both cursors, the
//   counters and every valid flag.
`timescale 1ns / 1ps

module link_impairment_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lis_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lis_pkg::CFG_DATA_W-1:0]     cfg_data,
  lis_stream_if.sink                         in_ch,
  lis_stream_if.source                       out_ch
);

  // Configuration registers.
  logic [lis_pkg::PCT_W-1:0] drop_pct_r;
  logic [lis_pkg::PCT_W-1:0] dup_pct_r;
  logic [lis_pkg::US_W-1:0]  jitter_r;
  logic [lis_pkg::US_W-1:0]  up_lat_r;
  logic [lis_pkg::US_W-1:0]  down_lat_r;
  logic                      ordered_r;

  // Pipeline registers.
  logic                  a_valid_r, a_valid_nxt;
  lis_pkg::in_item_t     a_item_r;
  lis_pkg::in_item_t     a_item_nxt;
  logic                  b_valid_r, b_valid_nxt;
  logic                  b_phase_r, b_phase_nxt;
  lis_pkg::b_item_t      b_item_r;
  lis_pkg::b_item_t      b_item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lis_pkg::out_item_t    out_item_r;
  lis_pkg::out_item_t    out_item_nxt;

  logic                      in_acc;
  logic                      b_take;
  logic                      b_load;
  logic                      b_issue;
  logic                      b_last;
  logic                      b_done;
  logic [lis_pkg::US_W-1:0]  base;
  lis_pkg::sched_req_t       req;
  lis_pkg::sched_res_t       res;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_pct_r <= '0;
      dup_pct_r  <= '0;
      jitter_r   <= '0;
      up_lat_r   <= '0;
      down_lat_r <= '0;
      ordered_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        lis_pkg::CFG_LOSS_PCT: drop_pct_r <= cfg_data[lis_pkg::PCT_W-1:0];
        lis_pkg::CFG_DUP_PCT:  dup_pct_r  <= cfg_data[lis_pkg::PCT_W-1:0];
        lis_pkg::CFG_JITTER:   jitter_r   <= cfg_data[lis_pkg::US_W-1:0];
        lis_pkg::CFG_UP_LAT:   up_lat_r   <= cfg_data[lis_pkg::US_W-1:0];
        lis_pkg::CFG_DOWN_LAT: down_lat_r <= cfg_data[lis_pkg::US_W-1:0];
        lis_pkg::CFG_ORDERED:  ordered_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake control across the three stages.
  assign b_last  = b_item_r.loss || !b_item_r.dup || b_phase_r;
  assign b_issue = b_valid_r && (!out_valid_r || out_ch.ready);
  assign b_done  = b_issue && b_last;
  assign b_take  = !b_valid_r || b_done;
  assign b_load  = a_valid_r && b_take;

  assign in_ch.ready = !a_valid_r || b_take;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Input stage: jitter draws are clamped to the configured maximum on entry.
  always_comb begin
    a_item_nxt = in_ch.data;
    if (in_ch.data.jitter_draw > jitter_r) begin
      a_item_nxt.jitter_draw = jitter_r;
    end
    if (in_ch.data.twin_jitter_draw > jitter_r) begin
      a_item_nxt.twin_jitter_draw = jitter_r;
    end
  end

  assign a_valid_nxt = in_acc ? 1'b1 : (b_take ? 1'b0 : a_valid_r);

  // Loss/duplicate decisions and nominal arrivals for both copies.
  assign base = a_item_r.upstream ? up_lat_r : down_lat_r;

  always_comb begin
    b_item_nxt.now_us    = a_item_r.now_us;
    b_item_nxt.pkt_id    = a_item_r.pkt_id & lis_pkg::ID_MASK;
    b_item_nxt.upstream  = a_item_r.upstream;
    b_item_nxt.loss      = a_item_r.loss_draw < drop_pct_r;
    b_item_nxt.dup       = a_item_r.dup_draw < dup_pct_r;
    b_item_nxt.nom1      = lis_pkg::NOM_W'(base) + lis_pkg::NOM_W'(a_item_r.jitter_draw);
    b_item_nxt.nom2      = lis_pkg::NOM_W'(base) + lis_pkg::NOM_W'(a_item_r.twin_jitter_draw);
    b_item_nxt.at1       = lis_pkg::SUM_W'(a_item_r.now_us) + lis_pkg::SUM_W'(base)
                           + lis_pkg::SUM_W'(a_item_r.jitter_draw);
    b_item_nxt.at2       = lis_pkg::SUM_W'(a_item_r.now_us) + lis_pkg::SUM_W'(base)
                           + lis_pkg::SUM_W'(a_item_r.twin_jitter_draw);
  end

  assign b_valid_nxt = b_load ? 1'b1 : (b_done ? 1'b0 : b_valid_r);
  assign b_phase_nxt = b_load ? 1'b0 : ((b_issue && !b_last) ? 1'b1 : b_phase_r);

  // Scheduling stage: the original copy first, then the twin against the moved cursor.
  always_comb begin
    req.now_us    = b_item_r.now_us;
    req.at        = b_phase_r ? b_item_r.at2 : b_item_r.at1;
    req.nom       = b_phase_r ? b_item_r.nom2 : b_item_r.nom1;
    req.upstream  = b_item_r.upstream;
    req.loss      = b_item_r.loss;
    req.dup       = b_item_r.dup;
    req.twin      = b_phase_r;
  end

  lis_sched u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .ordered (ordered_r),
    .issue   (b_issue),
    .req     (req),
    .res     (res)
  );

  // Result register.
  always_comb begin
    out_item_nxt.out_pkt_id       = b_item_r.pkt_id;
    out_item_nxt.is_twin          = b_phase_r;
    out_item_nxt.delay_us         = res.delay_us;
    out_item_nxt.toward_server    = b_item_r.upstream;
    out_item_nxt.was_dropped      = b_item_r.loss;
    out_item_nxt.link_reset       = b_item_r.loss && ordered_r;
    out_item_nxt.last             = b_last;
    out_item_nxt.sent_total       = res.sent_total;
    out_item_nxt.dropped_total    = res.dropped_total;
    out_item_nxt.duplicated_total = res.duplicated_total;
  end

  assign out_valid_nxt = b_issue ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      b_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      b_phase_r   <= b_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_item_r <= a_item_nxt;
    end
    if (b_load) begin
      b_item_r <= b_item_nxt;
    end
    if (b_issue) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Assertions.
  `include "link_impairment_scheduler_assert.svh"

  `LIS_ASSERT_NOW(a_twin_is_last, out_valid_r && out_item_r.is_twin, out_item_r.last && !out_item_r.was_dropped, "twin result must be the last and not dropped")
  `LIS_ASSERT_NOW(a_drop_single, out_valid_r && out_item_r.was_dropped, out_item_r.last && !out_item_r.is_twin && (out_item_r.delay_us == '0), "dropped packet must give one zero-delay result")
  `LIS_ASSERT_NOW(a_reset_on_drop, out_valid_r && out_item_r.link_reset, out_item_r.was_dropped, "link reset without a drop")
  `LIS_ASSERT_NEXT(a_twin_follows, b_issue && !b_last, b_valid_r && b_phase_r, "duplicate copy lost after the original issued")

endmodule
